FILE: rtl/hntns_pkg.sv
// Shared types, constants and byte classifier for the title-name scanner.
`timescale 1ns / 1ps

package hntns_pkg;

    localparam int unsigned WIN_LEN   = 20;
    localparam int unsigned DIGIT_LEN = 16;
    localparam int unsigned FILL_W    = 5;
    localparam int unsigned TITLE_W   = 64;

    localparam logic [7:0] CH_DOT  = 8'h2E;  // '.'
    localparam logic [7:0] CH_N_LO = 8'h6E;  // 'n'
    localparam logic [7:0] CH_N_UP = 8'h4E;  // 'N'
    localparam logic [7:0] CH_C_LO = 8'h63;  // 'c'
    localparam logic [7:0] CH_C_UP = 8'h43;  // 'C'
    localparam logic [7:0] CH_A_LO = 8'h61;  // 'a'
    localparam logic [7:0] CH_A_UP = 8'h41;  // 'A'
    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE  = 8'h31;  // '1'
    localparam logic [7:0] CH_NINE = 8'h39;  // '9'
    localparam logic [7:0] CH_F_LO = 8'h66;  // 'f'
    localparam logic [7:0] CH_F_UP = 8'h46;  // 'F'

    // One classified byte as it travels through the queue.
    typedef struct packed {
        logic       last;
        logic       is_hex;
        logic [3:0] nib;
        logic       is_dot;
        logic       is_n;
        logic       is_c;
        logic       is_a;
        logic       is_zero;
        logic       is_one;
    } t_cls;

    function automatic t_cls classify(input logic [7:0] b, input logic last);
        t_cls c;
        c         = '0;
        c.last    = last;
        c.is_dot  = (b == CH_DOT);
        c.is_n    = (b == CH_N_LO) || (b == CH_N_UP);
        c.is_c    = (b == CH_C_LO) || (b == CH_C_UP);
        c.is_a    = (b == CH_A_LO) || (b == CH_A_UP);
        c.is_zero = (b == CH_ZERO);
        c.is_one  = (b == CH_ONE);
        if (b >= CH_ZERO && b <= CH_NINE) begin
            c.is_hex = 1'b1;
            c.nib    = 4'(b - CH_ZERO);
        end else if (b >= CH_A_LO && b <= CH_F_LO) begin
            c.is_hex = 1'b1;
            c.nib    = 4'(b - CH_A_LO + 8'd10);
        end else if (b >= CH_A_UP && b <= CH_F_UP) begin
            c.is_hex = 1'b1;
            c.nib    = 4'(b - CH_A_UP + 8'd10);
        end
        return c;
    endfunction

endpackage

FILE: rtl/hntns_front.sv
// Front end: takes string-table words and classifies each byte into the queue.
`timescale 1ns / 1ps

module hntns_front (
    input  logic             i_valid,
    input  logic [7:0]       i_table_byte,
    input  logic             i_last_byte,
    input  logic             i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output hntns_pkg::t_cls  o_push_item
);
    import hntns_pkg::*;

    assign o_stall     = i_q_full;
    assign o_push      = i_valid && !i_q_full;
    assign o_push_item = classify(i_table_byte, i_last_byte);

endmodule

FILE: rtl/hntns_queue.sv
// Small first-word-fall-through queue of classified bytes.
`timescale 1ns / 1ps

module hntns_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hntns_pkg::t_cls  i_push_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_q_valid,
    output hntns_pkg::t_cls  o_head
);
    import hntns_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full    = (r_count == FULL_CNT);
    assign o_q_valid = (r_count != '0);
    assign o_head    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

FILE: rtl/hntns_back.sv
// Back end: sliding window, title-name match, latch and result register.
`timescale 1ns / 1ps

module hntns_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  hntns_pkg::t_cls                 i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_found,
    output logic [hntns_pkg::TITLE_W-1:0]   o_title_value
);
    import hntns_pkg::*;

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_LEN);

    t_cls                r_win [WIN_LEN];
    t_cls                n_win [WIN_LEN];
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_seen;
    logic [TITLE_W-1:0]  r_title;
    logic                r_out_valid;
    logic                r_out_found;
    logic [TITLE_W-1:0]  r_out_title;
    logic                hit;
    logic                all_hex;
    logic [TITLE_W-1:0]  win_value;

    assign o_pop         = i_q_valid && (!r_out_valid || !i_stall);
    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_title_value = r_out_title;

    // Window as it stands once the head byte is shifted in.
    always_comb begin
        for (int k = 0; k < WIN_LEN - 1; k++) begin
            n_win[k] = r_win[k+1];
        end
        n_win[WIN_LEN-1] = i_head;
        n_fill = (r_fill < FILL_MAX) ? r_fill + 1'b1 : r_fill;
    end

    always_comb begin
        all_hex = 1'b1;
        for (int k = 0; k < DIGIT_LEN; k++) begin
            all_hex = all_hex && n_win[k].is_hex;
            win_value[TITLE_W-1-4*k -: 4] = n_win[k].nib;
        end
        hit = (n_fill == FILL_MAX) && all_hex
            && n_win[DIGIT_LEN].is_dot && n_win[DIGIT_LEN+1].is_n
            && n_win[DIGIT_LEN+2].is_c && n_win[DIGIT_LEN+3].is_a
            && n_win[0].is_zero && n_win[1].is_one;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_head.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_head.last) begin
                    r_fill <= '0;
                    r_seen <= 1'b0;
                end else begin
                    r_fill <= n_fill;
                    if (hit) begin
                        r_seen <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < WIN_LEN; k++) begin
                r_win[k] <= n_win[k];
            end
            if (hit && !r_seen) begin
                r_title <= win_value;
            end
            if (i_head.last) begin
                r_out_found <= r_seen || hit;
                r_out_title <= r_seen ? r_title : (hit ? win_value : '0);
            end
        end
    end

endmodule

FILE: rtl/hex_title_nca_name_scanner.sv
// Top level of the title-name scanner: front classifier, queue, back matcher.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  input   | in        | i_valid / o_stall  | i_table_byte, i_last_byte
//  result  | out       | o_valid / i_stall  | o_found, o_title_value
//
// One word per cycle sustained while o_stall is low; the back end's window shift and
// parallel compare of all 20 positions are combinational on the queue head.
// A result is registered after its last-byte word is accepted (queue write,
// then back-end pop into the result register).
// Reset (i_rst_n low, synchronous) empties the queue and clears fill count,
// match latch and result valid; no clearing pass is needed.
// A stalled result only blocks the back end; the front keeps taking words
// until the queue is full, and then raises o_stall.
`timescale 1ns / 1ps

module hex_title_nca_name_scanner #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [7:0]   i_table_byte,
    input  logic         i_last_byte,
    output logic         o_valid,
    input  logic         i_stall,
    output logic         o_found,
    output logic [63:0]  o_title_value
);
    import hntns_pkg::*;

    logic push;
    logic q_full;
    logic q_valid;
    logic pop;
    t_cls push_item;
    t_cls head;

    // Front: byte classification and queue write.
    hntns_front u_front (
        .i_valid      (i_valid),
        .i_table_byte (i_table_byte),
        .i_last_byte  (i_last_byte),
        .i_q_full     (q_full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_push_item  (push_item)
    );

    // Decoupling queue so result stalls do not reach the input at once.
    hntns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_q_valid   (q_valid),
        .o_head      (head)
    );

    // Back: window, first-match latch, result register.
    hntns_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_title_value (o_title_value)
    );

endmodule

FILE: tb/hex_title_nca_name_scanner_test.sv
// Scoreboard testbench for the title-name scanner: tables in, found flag and title value out.
`timescale 1ns / 1ps

module hex_title_nca_name_scanner_test;

    import hntns_pkg::*;

    // Idle cycles with no handshake on either side before the run is called hung.
    // Worst honest case is the long result hold-off plus a stall burst, far below this.
    localparam int unsigned IDLE_LIMIT   = 1000;
    // Length of the one long result hold-off that fills the block and stalls its input.
    localparam int unsigned HOLD_CYCLES  = 100;
    // Stimulus size in bytes; tables are sent whole, so the total runs a little over.
    localparam int unsigned RAND_BYTES   = 800;
    // Where the long hold-off goes, and where the idle-free tail starts.
    localparam int unsigned HOLD_AT      = 250;
    localparam int unsigned QUIET_AT     = 680;
    // Extra cycles to wait after the last result is checked, before the verdict.
    localparam int unsigned TAIL_CYCLES  = 8;

    // One expected or observed result word.
    typedef struct packed {
        logic               found;
        logic [TITLE_W-1:0] value;
    } t_title_result;

    // Own model of the scanner plus the queue of results it predicts.
    class title_scoreboard;
        logic [7:0]         win [WIN_LEN];
        int unsigned        fill;
        bit                 seen;
        logic [TITLE_W-1:0] held;
        t_title_result      expected_titles[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        found_count;

        function new();
            errors      = 0;
            checked     = 0;
            found_count = 0;
            restart();
        endfunction

        function void restart();
            foreach (win[k]) win[k] = '0;
            fill = 0;
            seen = 1'b0;
            held = '0;
        endfunction

        function bit hex_nibble(input logic [7:0] c, output logic [3:0] n);
            n = '0;
            if (c >= CH_ZERO && c <= CH_NINE) n = 4'(c - CH_ZERO);
            else if (c >= CH_A_LO && c <= CH_F_LO) n = 4'(c - CH_A_LO + 8'd10);
            else if (c >= CH_A_UP && c <= CH_F_UP) n = 4'(c - CH_A_UP + 8'd10);
            else return 1'b0;
            return 1'b1;
        endfunction

        // Full-window test: 16 hex digits led by "01", then ".nca" in any case.
        function bit window_title(output logic [TITLE_W-1:0] value);
            logic [3:0] nib;
            int         k;
            value = '0;
            for (k = 0; k < DIGIT_LEN; k++) begin
                if (!hex_nibble(win[k], nib)) return 1'b0;
                value = {value[TITLE_W-5:0], nib};
            end
            if (win[16] != CH_DOT) return 1'b0;
            if (win[17] != CH_N_LO && win[17] != CH_N_UP) return 1'b0;
            if (win[18] != CH_C_LO && win[18] != CH_C_UP) return 1'b0;
            if (win[19] != CH_A_LO && win[19] != CH_A_UP) return 1'b0;
            return (win[0] == CH_ZERO) && (win[1] == CH_ONE);
        endfunction

        // Accepted input word: shift it in, latch the first match, predict on the last byte.
        function void note_byte(input logic [7:0] b, input logic last);
            logic [TITLE_W-1:0] v;
            t_title_result      r;
            int                 k;
            for (k = 0; k < WIN_LEN - 1; k++) win[k] = win[k + 1];
            win[WIN_LEN - 1] = b;
            if (fill < WIN_LEN) fill++;
            if (fill >= WIN_LEN && !seen && window_title(v)) begin
                seen = 1'b1;
                held = v;
            end
            if (last) begin
                r.found = seen;
                r.value = seen ? held : '0;
                expected_titles.push_back(r);
                restart();
            end
        endfunction

        // Accepted result word: compare with the oldest prediction.
        function void check_result(input logic found, input logic [TITLE_W-1:0] value);
            t_title_result e;
            if (expected_titles.size() == 0) begin
                $display("%0t: unexpected result found=%0b value=%016h", $time, found, value);
                errors++;
                return;
            end
            e = expected_titles.pop_front();
            checked++;
            if (e.found) found_count++;
            if (found !== e.found) begin
                $display("%0t: result %0d found: expected %0b actual %0b",
                         $time, checked, e.found, found);
                errors++;
            end
            if (value !== e.value) begin
                $display("%0t: result %0d title_value: expected %016h actual %016h",
                         $time, checked, e.value, value);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_titles.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_table_byte;
    logic               i_last_byte;
    logic               o_valid;
    logic               i_stall;
    logic               o_found;
    logic [TITLE_W-1:0] o_title_value;

    hex_title_nca_name_scanner i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_table_byte  (i_table_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_title_value (o_title_value)
    );

    title_scoreboard scan_board;

    logic [7:0]  strtab[$];       // table being built, sent as one unit
    bit          gapless;         // sender offers back to back
    bit          quiet;           // receiver never stalls
    bit          hold_req;        // ask the receiver for the long hold-off
    int unsigned bytes_sent;
    int unsigned tables_sent;
    int unsigned idle_cycles;
    int unsigned input_stalled;   // cycles a word was offered but held off by o_stall

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Monitors and watchdog, all at the rising edge on pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) scan_board.note_byte(i_table_byte, i_last_byte);
            if (i_valid && o_stall) input_stalled++;
            if (o_valid && !i_stall) scan_board.check_result(o_found, o_title_value);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                    $display("hex_title_nca_name_scanner_test: FAIL");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stall bursts, one long counted hold-off on request,
    // none at all once the quiet tail starts.
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall  <= 1'b0;
                hold_req = 1'b0;
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                i_stall <= 1'b0;
                // sometimes a long stretch with no stall at all
                if ($urandom_range(0, 7) == 0) repeat ($urandom_range(30, 80)) @(negedge i_clk);
                else repeat ($urandom_range(0, 20)) @(negedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    // Offer one word at the falling edge and hold it until it is taken.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [7:0] b, input logic last);
        if (!gapless && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_table_byte <= b;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Send the built table, flagging its final byte.
    task automatic send_strtab();
        int k;
        for (k = 0; k < strtab.size(); k++) begin
            send_word(strtab[k], k == strtab.size() - 1);
            bytes_sent++;
        end
        tables_sent++;
        strtab.delete();
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return CH_ZERO + 8'(v);
        return (upper ? CH_A_UP : CH_A_LO) + 8'(v) - 8'd10;
    endfunction

    // Bytes just outside the hex ranges, plus high-bit aliases of key characters.
    function automatic logic [7:0] boundary_byte();
        case ($urandom_range(0, 11))
            0:       return 8'h2F;   // '/'
            1:       return 8'h3A;   // ':'
            2:       return 8'h40;   // '@'
            3:       return 8'h47;   // 'G'
            4:       return 8'h60;   // '`'
            5:       return 8'h67;   // 'g'
            6:       return 8'h00;
            7:       return 8'hFF;
            8:       return CH_ZERO | 8'h80;
            9:       return CH_ONE | 8'h80;
            10:      return CH_DOT | 8'h80;
            default: return CH_N_LO | 8'h80;
        endcase
    endfunction

    // Filler biased toward characters that can almost form a title.
    function automatic logic [7:0] noise_byte();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) return hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1));
        if (pick < 10) return $urandom_range(0, 1) ? CH_ONE : CH_ZERO;
        if (pick < 12) begin
            case ($urandom_range(0, 6))
                0:       return CH_DOT;
                1:       return CH_N_LO;
                2:       return CH_N_UP;
                3:       return CH_C_LO;
                4:       return CH_C_UP;
                5:       return CH_A_LO;
                default: return CH_A_UP;
            endcase
        end
        if (pick < 15) return boundary_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_noise(input int unsigned n);
        repeat (n) strtab.push_back(noise_byte());
    endtask

    // Push a title name, optionally with one damaged byte (flaw >= 0),
    // and cut to the first keep bytes.
    task automatic push_title(input int flaw, input int unsigned keep);
        logic [7:0]  t [WIN_LEN];
        int unsigned mode;
        int          k;
        mode = $urandom_range(0, 7);
        t[0] = CH_ZERO;
        t[1] = CH_ONE;
        for (k = 2; k < DIGIT_LEN; k++) begin
            // all-F and all-zero digit runs hit the value extremes
            if (mode == 0) t[k] = hex_char(4'hF, $urandom_range(0, 1));
            else if (mode == 1) t[k] = CH_ZERO;
            else t[k] = hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1));
        end
        t[16] = CH_DOT;
        t[17] = $urandom_range(0, 1) ? CH_N_UP : CH_N_LO;
        t[18] = $urandom_range(0, 1) ? CH_C_UP : CH_C_LO;
        t[19] = $urandom_range(0, 1) ? CH_A_UP : CH_A_LO;
        if (flaw >= 0) begin
            if ($urandom_range(0, 1) == 0) t[flaw] = boundary_byte();
            else t[flaw] = t[flaw] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (k = 0; k < keep; k++) strtab.push_back(t[k]);
    endtask

    // One random table: mostly well-formed titles in random filler,
    // the rest short tables, plain noise, doubles and damaged titles.
    task automatic build_random_table();
        int unsigned kind;
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            // short table: never fills the window
            if ($urandom_range(0, 1) == 0) push_title(-1, $urandom_range(1, WIN_LEN - 1));
            else push_noise($urandom_range(1, WIN_LEN - 1));
        end else if (kind < 4) begin
            push_noise($urandom_range(WIN_LEN, 36));
        end else if (kind < 13) begin
            push_noise($urandom_range(0, 6));
            push_title(-1, WIN_LEN);
            push_noise($urandom_range(0, 4));
        end else if (kind < 15) begin
            // second title must be ignored
            push_noise($urandom_range(0, 3));
            push_title(-1, WIN_LEN);
            push_noise($urandom_range(0, 3));
            push_title(-1, WIN_LEN);
            push_noise($urandom_range(0, 2));
        end else begin
            push_noise($urandom_range(0, 5));
            if ($urandom_range(0, 3) == 0) push_title(-1, $urandom_range(1, WIN_LEN - 1));
            else push_title($urandom_range(0, WIN_LEN - 1), WIN_LEN);
            push_noise($urandom_range(0, 4));
        end
    endtask

    initial begin
        bit held_off;
        scan_board    = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_table_byte  = '0;
        i_last_byte   = 1'b0;
        gapless       = 1'b0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        held_off      = 1'b0;
        bytes_sent    = 0;
        tables_sent   = 0;
        idle_cycles   = 0;
        input_stalled = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: exact 20-byte table ending in a mixed-case title,
        // then a short table with the byte extremes right after it.
        strtab = '{CH_ZERO, CH_ONE, CH_A_LO, CH_F_UP, CH_NINE, CH_F_LO, CH_ZERO, CH_A_UP,
                   8'h62, 8'h43, 8'h64, 8'h45, 8'h35, 8'h36, 8'h37, 8'h38,
                   CH_DOT, CH_N_LO, CH_C_UP, CH_A_LO};
        send_strtab();
        strtab = '{8'h00, 8'hFF, CH_ONE};
        send_strtab();

        // Random tables until the byte count is met.
        while (bytes_sent < RAND_BYTES) begin
            if (!held_off && bytes_sent >= HOLD_AT) begin
                // back-to-back short tables while the result side is held off:
                // the queue fills and the block must stall its input
                held_off = 1'b1;
                gapless  = 1'b1;
                hold_req = 1'b1;
                while (hold_req) begin
                    push_noise($urandom_range(1, 4));
                    send_strtab();
                end
                gapless = 1'b0;
            end
            if (bytes_sent >= QUIET_AT) begin
                gapless = 1'b1;
                quiet   = 1'b1;
            end
            build_random_table();
            send_strtab();
        end
        i_valid <= 1'b0;

        // Drain; the watchdog catches a hang.
        while (scan_board.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Scanned %0d bytes in %0d tables; %0d results checked, %0d with a title.",
                 bytes_sent, tables_sent, scan_board.checked, scan_board.found_count);
        $display("Input held off by back-pressure for %0d cycles; longest result hold %0d.",
                 input_stalled, HOLD_CYCLES);
        if (scan_board.errors == 0 && scan_board.pending() == 0) begin
            $display("hex_title_nca_name_scanner_test: PASS");
        end else begin
            $display("hex_title_nca_name_scanner_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/hntns_pkg.sv
rtl/hntns_front.sv
rtl/hntns_queue.sv
rtl/hntns_back.sv
rtl/hex_title_nca_name_scanner.sv
tb/hex_title_nca_name_scanner_test.sv
